@@ hw/rtl/pcrt_pkg.sv @@
// Shared types, constants and register codes for the point cloud rigid transform core.
package pcrt_pkg;

    // Fixed field widths
    localparam int COORD_W    = 32;
    localparam int ANGLE_W    = 16;
    localparam int PHASE_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Defaults for the top-level parameters
    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_TRIG_FRAC_BITS   = 16;

    // One quarter turn in binary-angle units
    localparam int QUARTER_TURN = 16384;

    // Sine table generation: pi/2 in Q30 and series divisors (2n)(2n+1)
    localparam longint HALF_PI_Q30  = 64'd1686629713;
    localparam int     TAYLOR_TERMS = 10;
    localparam longint TAYLOR_DIV [1:TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [ANGLE_W-1:0]        t_angle;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_YAW      = 3'd0;
    localparam t_cfg_idx CFG_ROLL     = 3'd1;
    localparam t_cfg_idx CFG_PITCH    = 3'd2;
    localparam t_cfg_idx CFG_OFFSET_X = 3'd3;
    localparam t_cfg_idx CFG_OFFSET_Y = 3'd4;
    localparam t_cfg_idx CFG_OFFSET_Z = 3'd5;

endpackage

@@ hw/rtl/point_cloud_rigid_transform_core.sv @@
// Point cloud rigid transform core: yaw, roll, pitch rotation then translation.
// Stages: input register, two stages per rotation for yaw, roll and pitch, offset add
// into the output register. Throughput: one point per cycle unless the output stalls;
// every stage has its own valid bit and holds on a stall.
// Trig values follow an angle write through the angle register and the registered ROM read.
// Reset (synchronous, active low) clears all valid bits and the six registers to zero.
module point_cloud_rigid_transform_core #(
    parameter int SINE_TABLE_DEPTH = pcrt_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int TRIG_FRAC_BITS   = pcrt_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  pcrt_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [pcrt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input points
    input  logic                               i_valid,
    output logic                               o_ready,
    input  pcrt_pkg::t_coord                   i_in_x,
    input  pcrt_pkg::t_coord                   i_in_y,
    input  pcrt_pkg::t_coord                   i_in_z,
    input  logic                               i_point_finite,
    // output points
    output logic                               o_valid,
    input  logic                               i_ready,
    output pcrt_pkg::t_coord                   o_out_x,
    output pcrt_pkg::t_coord                   o_out_y,
    output pcrt_pkg::t_coord                   o_out_z
);

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;

    pcrt_pkg::t_angle   r_yaw;
    pcrt_pkg::t_angle   r_roll;
    pcrt_pkg::t_angle   r_pitch;
    pcrt_pkg::t_coord   r_off_x;
    pcrt_pkg::t_coord   r_off_y;
    pcrt_pkg::t_coord   r_off_z;

    logic signed [TRIG_W-1:0] yaw_sin;
    logic signed [TRIG_W-1:0] yaw_cos;
    logic signed [TRIG_W-1:0] roll_sin;
    logic signed [TRIG_W-1:0] roll_cos;
    logic signed [TRIG_W-1:0] pitch_sin;
    logic signed [TRIG_W-1:0] pitch_cos;

    logic               en_in;
    logic               r_s0_valid;
    pcrt_pkg::t_coord   r_s0_x;
    pcrt_pkg::t_coord   r_s0_y;
    pcrt_pkg::t_coord   r_s0_z;

    logic               yaw_ready;
    logic               yaw_valid;
    pcrt_pkg::t_coord   x1;
    pcrt_pkg::t_coord   y1;
    pcrt_pkg::t_coord   z1;
    logic               roll_ready;
    logic               roll_valid;
    pcrt_pkg::t_coord   y2;
    pcrt_pkg::t_coord   z2;
    pcrt_pkg::t_coord   x2;
    logic               pitch_ready;
    logic               pitch_valid;
    pcrt_pkg::t_coord   z3;
    pcrt_pkg::t_coord   x3;
    pcrt_pkg::t_coord   y3;

    logic               en_out;
    logic               r_o_valid;
    pcrt_pkg::t_coord   r_o_x;
    pcrt_pkg::t_coord   r_o_y;
    pcrt_pkg::t_coord   r_o_z;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= '0;
            r_roll  <= '0;
            r_pitch <= '0;
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcrt_pkg::CFG_YAW:      r_yaw   <= i_cfg_data[pcrt_pkg::ANGLE_W-1:0];
                pcrt_pkg::CFG_ROLL:     r_roll  <= i_cfg_data[pcrt_pkg::ANGLE_W-1:0];
                pcrt_pkg::CFG_PITCH:    r_pitch <= i_cfg_data[pcrt_pkg::ANGLE_W-1:0];
                pcrt_pkg::CFG_OFFSET_X: r_off_x <= i_cfg_data[pcrt_pkg::COORD_W-1:0];
                pcrt_pkg::CFG_OFFSET_Y: r_off_y <= i_cfg_data[pcrt_pkg::COORD_W-1:0];
                pcrt_pkg::CFG_OFFSET_Z: r_off_z <= i_cfg_data[pcrt_pkg::COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Trig lookups, one ROM pair per angle
    pcrt_trig #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .TRIG_FRAC_BITS   (TRIG_FRAC_BITS)
    ) u_yaw_trig (
        .i_clk   (i_clk),
        .i_angle (r_yaw),
        .o_sin   (yaw_sin),
        .o_cos   (yaw_cos)
    );

    pcrt_trig #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .TRIG_FRAC_BITS   (TRIG_FRAC_BITS)
    ) u_roll_trig (
        .i_clk   (i_clk),
        .i_angle (r_roll),
        .o_sin   (roll_sin),
        .o_cos   (roll_cos)
    );

    pcrt_trig #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .TRIG_FRAC_BITS   (TRIG_FRAC_BITS)
    ) u_pitch_trig (
        .i_clk   (i_clk),
        .i_angle (r_pitch),
        .o_sin   (pitch_sin),
        .o_cos   (pitch_cos)
    );

    // Input register; non-finite points are accepted and dropped here
    assign en_in   = !r_s0_valid || yaw_ready;
    assign o_ready = en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en_in) begin
            r_s0_valid <= i_valid && i_point_finite;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_s0_x <= i_in_x;
            r_s0_y <= i_in_y;
            r_s0_z <= i_in_z;
        end
    end

    // Yaw: rotate (x, y) about z
    pcrt_rot #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_yaw_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .o_ready (yaw_ready),
        .i_u     (r_s0_x),
        .i_v     (r_s0_y),
        .i_w     (r_s0_z),
        .i_sin   (yaw_sin),
        .i_cos   (yaw_cos),
        .o_valid (yaw_valid),
        .i_ready (roll_ready),
        .o_u     (x1),
        .o_v     (y1),
        .o_w     (z1)
    );

    // Roll: rotate (y, z) about x
    pcrt_rot #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_roll_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yaw_valid),
        .o_ready (roll_ready),
        .i_u     (y1),
        .i_v     (z1),
        .i_w     (x1),
        .i_sin   (roll_sin),
        .i_cos   (roll_cos),
        .o_valid (roll_valid),
        .i_ready (pitch_ready),
        .o_u     (y2),
        .o_v     (z2),
        .o_w     (x2)
    );

    // Pitch: rotate (z, x) about y
    pcrt_rot #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_pitch_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (roll_valid),
        .o_ready (pitch_ready),
        .i_u     (z2),
        .i_v     (x2),
        .i_w     (y2),
        .i_sin   (pitch_sin),
        .i_cos   (pitch_cos),
        .o_valid (pitch_valid),
        .i_ready (en_out),
        .o_u     (z3),
        .o_v     (x3),
        .o_w     (y3)
    );

    // Translation into the output register
    assign en_out = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_out) begin
            r_o_valid <= pitch_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_o_x <= x3 + r_off_x;
            r_o_y <= y3 + r_off_y;
            r_o_z <= z3 + r_off_z;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out_x = r_o_x;
    assign o_out_y = r_o_y;
    assign o_out_z = r_o_z;

    // A finite point taken at the input lands in the input register
    a_finite_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_point_finite |=> r_s0_valid)
        else $error("finite input beat not captured");

    // A non-finite point never enters the pipeline
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_point_finite |=> !r_s0_valid)
        else $error("non-finite input beat entered the pipeline");

    // A point held in the input register while stalled is not lost
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_valid && !yaw_ready |=> r_s0_valid && $stable(r_s0_x) && $stable(r_s0_z))
        else $error("stalled input register lost its point");

    // The output register only refills when it is empty or being drained
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !i_ready |=> r_o_valid && $stable(r_o_x) && $stable(r_o_y))
        else $error("output register overwritten while stalled");

endmodule

@@ hw/rtl/pcrt_trig.sv @@
// Sine and cosine of one binary angle from a quarter-wave ROM, registered read.
module pcrt_trig #(
    parameter int SINE_TABLE_DEPTH = pcrt_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int TRIG_FRAC_BITS   = pcrt_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                          i_clk,
    input  pcrt_pkg::t_angle              i_angle,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MAG_W = TRIG_FRAC_BITS + 1;
    localparam int MUL_W = pcrt_pkg::PHASE_W + IDX_W;

    typedef logic [MAG_W-1:0] t_rom_arr [SINE_TABLE_DEPTH+1];

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } t_rom_addr;

    // Quarter-wave table, Taylor series in Q30, rounded to the trig format
    function automatic t_rom_arr build_rom();
        t_rom_arr tab;
        longint   x;
        longint   x2;
        longint   term;
        longint   sum;
        longint   r;
        longint   one;
        one = longint'(1) <<< TRIG_FRAC_BITS;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (longint'(k) * pcrt_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= pcrt_pkg::TAYLOR_TERMS; n++) begin
                term = ((term * x2) >>> 30) / pcrt_pkg::TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
            if (r > one) begin
                r = one;
            end
            tab[k] = MAG_W'(r);
        end
        return tab;
    endfunction

    localparam t_rom_arr SINE_ROM = build_rom();

    // Fold the angle into the first quadrant and scale the phase to a table index
    function automatic t_rom_addr rom_addr(input pcrt_pkg::t_angle ang);
        t_rom_addr                   a;
        logic [pcrt_pkg::PHASE_W-1:0] phase;
        logic [MUL_W-1:0]            scaled;
        if (ang[14]) begin
            phase = pcrt_pkg::PHASE_W'(pcrt_pkg::QUARTER_TURN)
                    - pcrt_pkg::PHASE_W'(ang[13:0]);
        end else begin
            phase = pcrt_pkg::PHASE_W'(ang[13:0]);
        end
        // phase never exceeds a quarter turn, so the index never exceeds the depth
        scaled = MUL_W'(phase) * MUL_W'(SINE_TABLE_DEPTH);
        a.idx  = scaled[pcrt_pkg::PHASE_W-1 +: IDX_W];
        a.neg  = ang[15];
        return a;
    endfunction

    t_rom_addr        sin_addr;
    t_rom_addr        cos_addr;
    logic [MAG_W-1:0] r_sin_mag;
    logic [MAG_W-1:0] r_cos_mag;
    logic             r_sin_neg;
    logic             r_cos_neg;

    // Cosine is the sine a quarter turn ahead
    assign sin_addr = rom_addr(i_angle);
    assign cos_addr = rom_addr(i_angle + pcrt_pkg::ANGLE_W'(pcrt_pkg::QUARTER_TURN));

    // Two registered ROM reads per cycle
    always_ff @(posedge i_clk) begin
        r_sin_mag <= SINE_ROM[sin_addr.idx];
        r_cos_mag <= SINE_ROM[cos_addr.idx];
        r_sin_neg <= sin_addr.neg;
        r_cos_neg <= cos_addr.neg;
    end

    // Apply the half-turn sign
    assign o_sin = r_sin_neg ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
    assign o_cos = r_cos_neg ? -$signed({1'b0, r_cos_mag}) : $signed({1'b0, r_cos_mag});

endmodule

@@ hw/rtl/pcrt_rot.sv @@
// One plane rotation: product stage then sum-and-round stage, with stall handling.
module pcrt_rot #(
    parameter int TRIG_FRAC_BITS = pcrt_pkg::DEF_TRIG_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  pcrt_pkg::t_coord                 i_u,
    input  pcrt_pkg::t_coord                 i_v,
    input  pcrt_pkg::t_coord                 i_w,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_sin,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_cos,
    output logic                             o_valid,
    input  logic                             i_ready,
    output pcrt_pkg::t_coord                 o_u,
    output pcrt_pkg::t_coord                 o_v,
    output pcrt_pkg::t_coord                 o_w
);

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int PROD_W = pcrt_pkg::COORD_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] HALF_LSB =
        {{(SUM_W-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

    logic                     en_prod;
    logic                     en_sum;
    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_uc;
    logic signed [PROD_W-1:0] r_vs;
    logic signed [PROD_W-1:0] r_us;
    logic signed [PROD_W-1:0] r_vc;
    pcrt_pkg::t_coord         r_p_w;
    logic                     r_s_valid;
    pcrt_pkg::t_coord         r_u;
    pcrt_pkg::t_coord         r_v;
    pcrt_pkg::t_coord         r_w;
    logic signed [SUM_W-1:0]  n_u_sum;
    logic signed [SUM_W-1:0]  n_v_sum;

    // A stage moves when it is empty or its successor moves
    assign en_sum  = !r_s_valid || i_ready;
    assign en_prod = !r_p_valid || en_sum;
    assign o_ready = en_prod;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (en_prod) begin
                r_p_valid <= i_valid;
            end
            if (en_sum) begin
                r_s_valid <= r_p_valid;
            end
        end
    end

    // Products of the coordinates with sine and cosine
    always_ff @(posedge i_clk) begin
        if (en_prod) begin
            r_uc  <= PROD_W'(i_u) * PROD_W'(i_cos);
            r_vs  <= PROD_W'(i_v) * PROD_W'(i_sin);
            r_us  <= PROD_W'(i_u) * PROD_W'(i_sin);
            r_vc  <= PROD_W'(i_v) * PROD_W'(i_cos);
            r_p_w <= i_w;
        end
    end

    // u' = c*u - s*v, v' = s*u + c*v, rounded half up, wrapped to 32 bits
    assign n_u_sum = SUM_W'(r_uc) - SUM_W'(r_vs) + HALF_LSB;
    assign n_v_sum = SUM_W'(r_us) + SUM_W'(r_vc) + HALF_LSB;

    always_ff @(posedge i_clk) begin
        if (en_sum) begin
            r_u <= n_u_sum[TRIG_FRAC_BITS +: pcrt_pkg::COORD_W];
            r_v <= n_v_sum[TRIG_FRAC_BITS +: pcrt_pkg::COORD_W];
            r_w <= r_p_w;
        end
    end

    assign o_valid = r_s_valid;
    assign o_u     = r_u;
    assign o_v     = r_v;
    assign o_w     = r_w;

endmodule

@@ sim/point_cloud_rigid_transform_core_tb.sv @@
// Self-checking testbench for the point cloud rigid transform core.
`timescale 1ns / 1ps

module point_cloud_rigid_transform_core_tb;
    import pcrt_pkg::*;

    localparam int LUT_DEPTH      = DEF_SINE_TABLE_DEPTH;
    localparam int FRAC           = DEF_TRIG_FRAC_BITS;
    localparam int SETTLE_CYCLES  = 12;    // pipeline is 8 deep, plus margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_CAP      = 50;

    // Indexes past the last register; writes there must be ignored
    localparam t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    localparam t_coord COORD_MAX = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN = 32'sh8000_0000;
    localparam t_coord ONE_M     = 32'sh0001_0000;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } map_point_t;

    // DUT signals
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    t_cfg_idx              i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    t_coord                i_in_x         = '0;
    t_coord                i_in_y         = '0;
    t_coord                i_in_z         = '0;
    logic                  i_point_finite = 1'b0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    t_coord                o_out_x;
    t_coord                o_out_y;
    t_coord                o_out_z;

    // Predictor state: pose registers and the quarter-wave sine table
    t_angle     pose_yaw, pose_roll, pose_pitch;
    t_coord     pose_off_x, pose_off_y, pose_off_z;
    longint     sin_lut [0:LUT_DEPTH];
    map_point_t pending_map_points [$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  src_gaps_on    = 1'b1;
    bit  sink_stalls_on = 1'b1;

    point_cloud_rigid_transform_core #(
        .SINE_TABLE_DEPTH (LUT_DEPTH),
        .TRIG_FRAC_BITS   (FRAC)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_x         (i_in_x),
        .i_in_y         (i_in_y),
        .i_in_z         (i_in_z),
        .i_point_finite (i_point_finite),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // sin(k * pi/2 / depth): Taylor series in Q30, then rounded to Q(FRAC)
    function automatic longint lut_entry(int k);
        longint x, x2, term, acc, r, one;
        x    = (longint'(k) * HALF_PI_Q30) / LUT_DEPTH;
        x2   = (x * x) >>> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= term;
            else            acc += term;
        end
        if (acc < 0) acc = 0;
        one = longint'(1) <<< FRAC;
        r   = (acc + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
        return (r > one) ? one : r;
    endfunction

    // Quarter-wave lookup: odd quadrants mirror the phase, upper half negates
    function automatic longint lut_sin(t_angle ang);
        logic [ANGLE_W-3:0] phase;
        int unsigned        span, slot;
        phase = ang[ANGLE_W-3:0];
        span  = ang[ANGLE_W-2] ? (QUARTER_TURN - phase) : phase;
        slot  = (span * LUT_DEPTH) >> (ANGLE_W - 2);
        if (slot > LUT_DEPTH) slot = LUT_DEPTH;
        return ang[ANGLE_W-1] ? -sin_lut[slot] : sin_lut[slot];
    endfunction

    function automatic longint lut_cos(t_angle ang);
        return lut_sin(t_angle'(ang + QUARTER_TURN));
    endfunction

    // a*ca + b*cb, round to nearest with ties up, wrap to 32 bits
    function automatic t_coord mac_round(longint a, longint ca, longint b, longint cb);
        longint acc;
        acc = a * ca + b * cb;
        acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        return t_coord'(acc[COORD_W-1:0]);
    endfunction

    // Yaw about z, roll about x, pitch about y, then translate
    function automatic map_point_t predict_map_point(t_coord px, t_coord py, t_coord pz);
        longint     sy, cy, sr, cr, sp, cp;
        t_coord     x1, y1, y2, z2, x3, z3;
        map_point_t res;
        sy = lut_sin(pose_yaw);
        cy = lut_cos(pose_yaw);
        sr = lut_sin(pose_roll);
        cr = lut_cos(pose_roll);
        sp = lut_sin(pose_pitch);
        cp = lut_cos(pose_pitch);
        x1 = mac_round(px, cy, py, -sy);
        y1 = mac_round(px, sy, py, cy);
        y2 = mac_round(y1, cr, pz, -sr);
        z2 = mac_round(y1, sr, pz, cr);
        x3 = mac_round(x1, cp, z2, sp);
        z3 = mac_round(z2, cp, x1, -sp);
        res.x = x3 + pose_off_x;
        res.y = y2 + pose_off_y;
        res.z = z3 + pose_off_z;
        return res;
    endfunction

    function automatic void pose_model_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_YAW:      pose_yaw   = data[ANGLE_W-1:0];
            CFG_ROLL:     pose_roll  = data[ANGLE_W-1:0];
            CFG_PITCH:    pose_pitch = data[ANGLE_W-1:0];
            CFG_OFFSET_X: pose_off_x = data;
            CFG_OFFSET_Y: pose_off_y = data;
            CFG_OFFSET_Z: pose_off_z = data;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Random value helpers
    // ---------------------------------------------------------------

    // Mix of full range, within 16 metres of the origin, and the extremes
    function automatic t_coord rand_coord();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            case ($urandom_range(3))
                0:       return COORD_MAX;
                1:       return COORD_MIN;
                2:       return '0;
                default: return -1;
            endcase
        end else if (pick < 4) begin
            return t_coord'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        end
        return t_coord'($urandom);
    endfunction

    // Angle with junk in the unused upper bits; quadrant edges now and then
    function automatic logic [CFG_DATA_W-1:0] rand_angle_word();
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(7))
                0: word[ANGLE_W-1:0] = 16'h0000;
                1: word[ANGLE_W-1:0] = 16'h4000;
                2: word[ANGLE_W-1:0] = 16'h8000;
                3: word[ANGLE_W-1:0] = 16'hC000;
                4: word[ANGLE_W-1:0] = 16'h7FFF;
                5: word[ANGLE_W-1:0] = 16'hFFFF;
                6: word[ANGLE_W-1:0] = 16'h3FFF;
                default: word[ANGLE_W-1:0] = 16'h0001;
            endcase
        end
        return word;
    endfunction

    // ---------------------------------------------------------------
    // Reporting and result checking
    // ---------------------------------------------------------------

    task automatic flag_error(input string msg);
        if (mismatch_count < PRINT_CAP) $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_coord(input string name, input t_coord got, input t_coord want);
        if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Output side: compare each beat with the oldest prediction, then pick next ready
    always @(posedge i_clk) begin
        map_point_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_map_points.size() == 0) begin
                flag_error($sformatf("unexpected output point %h %h %h",
                                     o_out_x, o_out_y, o_out_z));
            end else begin
                want = pending_map_points.pop_front();
                check_coord("out_x", o_out_x, want.x);
                check_coord("out_y", o_out_y, want.y);
                check_coord("out_z", o_out_z, want.z);
            end
        end
        i_ready <= !sink_stalls_on || ($urandom_range(99) >= 20);
    end

    // Watchdog: stop when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else                                              quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------

    // Offer one point and hold it until accepted; predict on acceptance
    task automatic send_point(input t_coord px, input t_coord py, input t_coord pz,
                              input logic finite);
        int gap;
        if (src_gaps_on && $urandom_range(99) < 12) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_in_x         <= px;
        i_in_y         <= py;
        i_in_z         <= pz;
        i_point_finite <= finite;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (finite) pending_map_points.push_back(predict_map_point(px, py, pz));
    endtask

    // Drop valid, wait for every predicted point, then let the pipeline settle
    task automatic wait_scan_done();
        i_valid <= 1'b0;
        while (pending_map_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        pose_model_write(idx, data);
        @(posedge i_clk);
    endtask

    // Load a full pose; the block must be idle
    task automatic apply_pose(input logic [CFG_DATA_W-1:0] yaw, input logic [CFG_DATA_W-1:0] roll,
                              input logic [CFG_DATA_W-1:0] pitch, input t_coord ox,
                              input t_coord oy, input t_coord oz);
        cfg_write(CFG_YAW, yaw);
        cfg_write(CFG_ROLL, roll);
        cfg_write(CFG_PITCH, pitch);
        cfg_write(CFG_OFFSET_X, ox);
        cfg_write(CFG_OFFSET_Y, oy);
        cfg_write(CFG_OFFSET_Z, oz);
        i_cfg_we <= 1'b0;
        // trig ROM output is registered
        repeat (3) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset pose is the identity: points pass through unchanged
    task automatic test_reset_pose();
        send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
        send_point(COORD_MIN, COORD_MAX, -1, 1'b1);
        send_point('0, '0, '0, 1'b1);
        send_point(ONE_M, -ONE_M, 32'sh1234_5678, 1'b1);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);   // non-finite, dropped
        send_point(32'sh0000_0001, -1, COORD_MIN, 1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        wait_scan_done();
    endtask

    // Extreme angles and offsets, wrap on overflow, quadrant edges
    task automatic test_pose_extremes();
        apply_pose(32'h0000_7FFF, 32'h0000_8000, 32'h0000_4000,
                   COORD_MAX, COORD_MIN, COORD_MAX);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        send_point(ONE_M, -ONE_M, 32'sh0123_4567, 1'b1);
        send_point(-1, 32'sh0000_0001, '0, 1'b1);
        send_point(ONE_M, ONE_M, ONE_M, 1'b0);
        wait_scan_done();

        apply_pose(32'hFFFF_8000, 32'hFFFF_FFFF, 32'h0000_C000,
                   COORD_MIN, COORD_MAX, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
        send_point(32'sh7FFF_0000, 32'sh0000_FFFF, -ONE_M, 1'b1);
        send_point('0, '0, '0, 1'b1);
        send_point(COORD_MIN, '0, COORD_MAX, 1'b0);
        wait_scan_done();
    endtask

    // Writes past the last register index change nothing
    task automatic test_spare_index();
        apply_pose(32'h0000_2000, 32'h0000_1000, 32'h0000_F000,
                   ONE_M, -ONE_M, 32'sh0000_8000);
        cfg_write(CFG_SPARE_LO, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE_HI, 32'hA5A5_5A5A);
        i_cfg_we <= 1'b0;
        repeat (3) @(posedge i_clk);
        send_point(ONE_M, ONE_M, ONE_M, 1'b1);
        send_point(COORD_MAX, -1, COORD_MIN, 1'b1);
        send_point(-ONE_M, 32'sh0003_0000, 32'sh0000_4000, 1'b1);
        wait_scan_done();
    endtask

    // Random scans: new pose per scan, mostly finite points, random content
    task automatic test_random_scans(input int scans, input int points_per_scan);
        for (int s = 0; s < scans; s++) begin
            apply_pose(rand_angle_word(), rand_angle_word(), rand_angle_word(),
                       rand_coord(), rand_coord(), rand_coord());
            for (int p = 0; p < points_per_scan; p++)
                send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(99) < 85);
            wait_scan_done();
        end
    endtask

    // Same traffic with no idling on either side: one beat per cycle
    task automatic test_full_rate(input int points);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_scans(1, points);
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        for (int k = 0; k <= LUT_DEPTH; k++) sin_lut[k] = lut_entry(k);
        pose_yaw   = '0;
        pose_roll  = '0;
        pose_pitch = '0;
        pose_off_x = '0;
        pose_off_y = '0;
        pose_off_z = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_pose();
        test_pose_extremes();
        test_spare_index();
        test_random_scans(11, 150);
        test_full_rate(200);

        wait_scan_done();
        if (pending_map_points.size() != 0)
            flag_error($sformatf("%0d output points never arrived", pending_map_points.size()));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
